### src/hft_pkg.sv
// ----------------------------------------------------------------------------
// hft_pkg: shared types and constants for the Hilbert FIR transformer
// Request structs, cell control, sample/product widths and the tap table.
// ----------------------------------------------------------------------------
package hft_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_W          = 15;
  localparam int COEF_FRAC_BITS  = 15;
  localparam int DIFF_W          = SAMPLE_WIDTH + 1;
  localparam int PROD_W          = DIFF_W + COEF_W;
  localparam int HALF_LENGTH_DEF = 30;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           trace_end;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           out_last;
  } out_req_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Magnitude of the tapered tap at odd offset k, Q0.15; zero elsewhere.
  function automatic logic [COEF_W-1:0] coef(input int k);
    logic [COEF_W-1:0] c;
    unique case (k)
      1:       c = COEF_W'(20808);
      3:       c = COEF_W'(6797);
      5:       c = COEF_W'(3915);
      7:       c = COEF_W'(2628);
      9:       c = COEF_W'(1878);
      11:      c = COEF_W'(1379);
      13:      c = COEF_W'(1020);
      15:      c = COEF_W'(751);
      17:      c = COEF_W'(545);
      19:      c = COEF_W'(387);
      21:      c = COEF_W'(268);
      23:      c = COEF_W'(180);
      25:      c = COEF_W'(118);
      27:      c = COEF_W'(79);
      29:      c = COEF_W'(59);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### src/hft_cell.sv
// ----------------------------------------------------------------------------
// hft_cell: one stage of the sample delay line
// Holds one sample, takes its neighbour's sample on a shift, clears to zero.
// ----------------------------------------------------------------------------
module hft_cell (
  input  logic                                   clk,
  input  hft_pkg::cell_ctrl_t                    ctrl,
  input  logic signed [hft_pkg::SAMPLE_WIDTH-1:0] prev,
  output logic signed [hft_pkg::SAMPLE_WIDTH-1:0] tap
);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      tap <= '0;
    end else if (ctrl.shift) begin
      tap <= prev;
    end
  end

endmodule

### src/hft_tree.sv
// ----------------------------------------------------------------------------
// hft_tree: registered adder tree, rounding, saturation and result register
// Sums the tap products one tree level per cycle unless a result stall holds
// the tree, then rounds half up and saturates into the result register.
// ----------------------------------------------------------------------------
module hft_tree #(
  parameter int NPAIR = (hft_pkg::HALF_LENGTH_DEF + 1) / 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  prod_valid,
  input  logic                                  prod_last,
  input  logic signed [hft_pkg::PROD_W-1:0]     prod [NPAIR],
  output logic                                  prod_ready,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output hft_pkg::out_req_t                     result
);

  localparam int LVL    = (NPAIR > 1) ? $clog2(NPAIR) : 1;
  localparam int LEAVES = 1 << LVL;
  localparam int ACC_W  = hft_pkg::PROD_W + LVL;
  localparam int SH_W   = ACC_W - hft_pkg::COEF_FRAC_BITS + 1;
  localparam logic signed [ACC_W:0] RND = (ACC_W + 1)'(1) <<< (hft_pkg::COEF_FRAC_BITS - 1);
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((2 ** (hft_pkg::SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-(2 ** (hft_pkg::SAMPLE_WIDTH - 1)));

  logic signed [ACC_W-1:0] node [1:LEAVES-1];
  logic signed [ACC_W-1:0] all  [1:2*LEAVES-1];
  logic [LVL:0] tv;
  logic [LVL:0] tl;
  logic [LVL:0] ld;
  logic out_en;

  logic signed [ACC_W:0]                    biased;
  logic signed [SH_W-1:0]                   shifted;
  logic signed [hft_pkg::SAMPLE_WIDTH-1:0]  sat_val;

  assign out_en     = !result_valid || !result_stall;
  assign tv[LVL]    = prod_valid;
  assign tl[LVL]    = prod_last;
  assign ld[0]      = out_en;
  assign prod_ready = ld[LVL];

  for (genvar d = 1; d <= LVL; d++) begin : g_ld
    assign ld[d] = !tv[d-1] || ld[d-1];
  end

  for (genvar d = 0; d < LVL; d++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        tv[d] <= 1'b0;
      end else if (ld[d+1]) begin
        tv[d] <= tv[d+1];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[d+1]) begin
        tl[d] <= tl[d+1];
      end
    end
  end

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < NPAIR) begin : g_used
      assign all[LEAVES+i] = ACC_W'(prod[i]);
    end else begin : g_pad
      assign all[LEAVES+i] = '0;
    end
  end

  for (genvar i = 1; i < LEAVES; i++) begin : g_node
    localparam int D = $clog2(i + 1) - 1;
    always_ff @(posedge clk) begin
      if (ld[D+1]) begin
        node[i] <= all[2*i] + all[2*i+1];
      end
    end
    assign all[i] = node[i];
  end

  // round half up, then clamp to the sample range
  assign biased  = (ACC_W + 1)'(all[1]) + RND;
  assign shifted = $signed(biased[ACC_W:hft_pkg::COEF_FRAC_BITS]);

  always_comb begin
    priority if (shifted > SAT_HI) begin
      sat_val = hft_pkg::SAMPLE_WIDTH'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat_val = hft_pkg::SAMPLE_WIDTH'(SAT_LO);
    end else begin
      sat_val = shifted[hft_pkg::SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= tv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      result.sample_out <= sat_val;
      result.out_last   <= tl[0];
    end
  end

endmodule

### src/hilbert_fir_transformer.sv
// ----------------------------------------------------------------------------
// hilbert_fir_transformer: streaming 61-tap Hilbert FIR
// Pipeline: difference register, product register, the adder tree (LVL
//   levels deep) and the result register.
// Throughput: one request per cycle unless the output stalls; a trace end
//   holds off requests while the delay line is flushed with zeros.
// Reset clears the delay line, the fill and flush counters and all valids.
// ----------------------------------------------------------------------------
module hilbert_fir_transformer #(
  parameter int HALF_LENGTH = hft_pkg::HALF_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  hft_pkg::in_req_t  sample,
  output logic              result_valid,
  input  logic              result_stall,
  output hft_pkg::out_req_t result
);

  localparam int NPAIR = (HALF_LENGTH + 1) / 2;
  localparam int NCELL = HALF_LENGTH + 2 * NPAIR - 1;
  localparam int CNT_W = $clog2(HALF_LENGTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HALF_LENGTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic signed [hft_pkg::SAMPLE_WIDTH-1:0] chain [0:NCELL];
  logic signed [hft_pkg::DIFF_W-1:0]       diff  [NPAIR];
  logic signed [hft_pkg::PROD_W-1:0]       prod  [NPAIR];
  hft_pkg::cell_ctrl_t ctrl;

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] flush_cnt;
  logic flushing;
  logic acc, push, flush_step, flush_done, emit;
  logic adv1, adv2, tree_ready;
  logic s1_valid, s1_last, s2_valid, s2_last;

  assign adv2         = !s2_valid || tree_ready;
  assign adv1         = !s1_valid || adv2;
  assign sample_stall = flushing || !adv1;
  assign acc          = sample_valid && !sample_stall;
  assign flush_step   = flushing && adv1;
  assign push         = acc || flush_step;
  assign flush_done   = flush_step && (flush_cnt == CNT_ONE);
  assign emit         = (fill == CNT_FULL);

  assign chain[0]   = acc ? sample.sample_in : '0;
  assign ctrl.shift = push;
  assign ctrl.clear = rst || flush_done;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    hft_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .prev (chain[c]),
      .tap  (chain[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst || flush_done) begin
      fill <= '0;
    end else if (push && !emit) begin
      fill <= fill + CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing  <= 1'b0;
      flush_cnt <= '0;
    end else if (acc && sample.trace_end) begin
      flushing  <= 1'b1;
      flush_cnt <= CNT_FULL;
    end else if (flush_done) begin
      flushing  <= 1'b0;
    end else if (flush_step) begin
      flush_cnt <= flush_cnt - CNT_ONE;
    end
  end

  // window after the push, read one place back on the pre-push line
  for (genvar p = 0; p < NPAIR; p++) begin : g_pair
    localparam int K = 2 * p + 1;
    logic signed [hft_pkg::PROD_W:0] full;

    assign full = (hft_pkg::PROD_W + 1)'(diff[p])
                * (hft_pkg::PROD_W + 1)'($signed({1'b0, hft_pkg::coef(K)}));

    always_ff @(posedge clk) begin
      if (adv1) begin
        diff[p] <= hft_pkg::DIFF_W'(chain[HALF_LENGTH-K])
                 - hft_pkg::DIFF_W'(chain[HALF_LENGTH+K]);
      end
      if (adv2) begin
        prod[p] <= full[hft_pkg::PROD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= push && emit;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_last <= flush_done;
    end
    if (adv2) begin
      s2_last <= s1_last;
    end
  end

  hft_tree #(
    .NPAIR (NPAIR)
  ) u_tree (
    .clk          (clk),
    .rst          (rst),
    .prod_valid   (s2_valid),
    .prod_last    (s2_last),
    .prod         (prod),
    .prod_ready   (tree_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (acc && sample.trace_end) |=> (flushing && flush_cnt == CNT_FULL))
    else $error("trace end did not start a full flush");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    flush_done |=> (fill == '0 && !flushing))
    else $error("history not cleared after flush");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    flush_done |=> (s1_valid && s1_last))
    else $error("final flush request produced no last result");

endmodule

### verif/hilbert_fir_transformer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hilbert_fir_transformer_tb: self-checking bench for the Hilbert FIR
// Streams traces of varying length and content through the block under random
// sender idling and receiver stalls, and predicts every output sample from a
// software delay line and tap table held in a small scoreboard.
// ----------------------------------------------------------------------------
module hilbert_fir_transformer_tb;

  localparam int HALF        = hft_pkg::HALF_LENGTH_DEF;
  localparam int TAPS        = 2 * HALF + 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 3;
  localparam int SEND_IDLE_PCT [PHASES] = '{35, 68, 0};
  localparam int RECV_STALL_PCT[PHASES] = '{68, 35, 0};
  localparam int PHASE_TARGET  [PHASES] = '{170, 320, 470};
  localparam logic signed [hft_pkg::SAMPLE_WIDTH-1:0] RAIL_HI = 16'sh7fff;
  localparam logic signed [hft_pkg::SAMPLE_WIDTH-1:0] RAIL_LO = 16'sh8000;

  // odd taps only; index is the offset from the centre
  localparam int TAP_MAG [0:HALF] = '{
    0, 20808, 0, 6797, 0, 3915, 0, 2628, 0, 1878, 0, 1379, 0, 1020, 0, 751,
    0, 545, 0, 387, 0, 268, 0, 180, 0, 118, 0, 79, 0, 59, 0
  };

  typedef enum int {WIDE_NOISE, LOW_LEVEL, RAIL_STEPS} trace_style_t;

  class hilbert_scoreboard;
    longint            delay_line[TAPS];
    int                fill;
    hft_pkg::out_req_t expected_outputs[$];
    int                errors;

    function new();
      foreach (delay_line[i]) delay_line[i] = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function void shift_in(longint v);
      for (int i = TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
      delay_line[0] = v;
    endfunction

    function hft_pkg::out_req_t transformed_sample(logic last);
      longint            acc;
      longint            rounded;
      hft_pkg::out_req_t r;
      acc = 0;
      for (int k = 1; k <= HALF; k++)
        acc += longint'(TAP_MAG[k]) * (delay_line[HALF-k] - delay_line[HALF+k]);
      rounded = (acc + (longint'(1) <<< (hft_pkg::COEF_FRAC_BITS - 1)))
                >>> hft_pkg::COEF_FRAC_BITS;
      if (rounded > longint'(RAIL_HI)) rounded = longint'(RAIL_HI);
      if (rounded < longint'(RAIL_LO)) rounded = longint'(RAIL_LO);
      r.sample_out = hft_pkg::SAMPLE_WIDTH'(rounded);
      r.out_last   = last;
      return r;
    endfunction

    function void note_request(hft_pkg::in_req_t req);
      int prior;
      prior = fill;
      shift_in(longint'(req.sample_in));
      if (prior >= HALF) begin
        expected_outputs.push_back(transformed_sample(1'b0));
      end else begin
        fill = prior + 1;
      end
      if (req.trace_end) begin
        // flush with zeros; the final flushed output always carries the last flag
        for (int s = 1; s <= HALF; s++) begin
          shift_in(0);
          if (prior >= HALF || s >= HALF - prior)
            expected_outputs.push_back(transformed_sample(s == HALF));
        end
        foreach (delay_line[i]) delay_line[i] = 0;
        fill = 0;
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(hft_pkg::out_req_t got);
      hft_pkg::out_req_t want;
      if (expected_outputs.size() == 0) begin
        report_mismatch("unexpected output sample", int'(got.sample_out), 0);
        return;
      end
      want = expected_outputs.pop_front();
      if (got.sample_out !== want.sample_out)
        report_mismatch("sample_out", int'(got.sample_out), int'(want.sample_out));
      if (got.out_last !== want.out_last)
        report_mismatch("out_last", int'(got.out_last), int'(want.out_last));
    endtask
  endclass

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  hft_pkg::in_req_t  sample       = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  hft_pkg::out_req_t result;

  hilbert_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int requests_sent  = 0;
  int quiet_cycles   = 0;

  hilbert_fir_transformer i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) sb.note_request(sample);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input hft_pkg::in_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= req;
    do @(posedge clk); while (sample_stall);
    requests_sent++;
  endtask

  task automatic send_sample(input logic signed [hft_pkg::SAMPLE_WIDTH-1:0] v,
                             input logic last);
    hft_pkg::in_req_t req;
    req.sample_in = v;
    req.trace_end = last;
    send_request(req);
  endtask

  task automatic send_random_trace();
    int           len;
    int           pick;
    trace_style_t style;
    logic signed [hft_pkg::SAMPLE_WIDTH-1:0] level;
    logic signed [hft_pkg::SAMPLE_WIDTH-1:0] v;
    pick = $urandom_range(9);
    if (pick < 3) begin
      len = $urandom_range(1, HALF);
    end else if (pick < 9) begin
      len = $urandom_range(HALF + 1, 70);
    end else begin
      len = $urandom_range(71, 120);
    end
    style = trace_style_t'($urandom_range(2));
    level = RAIL_HI;
    for (int i = 0; i < len; i++) begin
      case (style)
        WIDE_NOISE: begin
          v = hft_pkg::SAMPLE_WIDTH'($urandom);
        end
        LOW_LEVEL: begin
          v = hft_pkg::SAMPLE_WIDTH'($urandom_range(4095)) - 16'sd2048;
        end
        default: begin
          // long runs on one rail drive the sum into saturation
          if ($urandom_range(7) == 0) level = ~level;
          v = level;
        end
      endcase
      send_sample(v, i == len - 1);
    end
  endtask

  task automatic wait_for_drain();
    sample_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      if (p == 0) begin
        // one-sample traces at both rails, then a short rail-to-rail step
        send_sample(RAIL_HI, 1'b1);
        send_sample(RAIL_LO, 1'b1);
        for (int i = 0; i < 22; i++) send_sample(i < 11 ? RAIL_LO : RAIL_HI, i == 21);
      end
      while (requests_sent < PHASE_TARGET[p]) send_random_trace();
      wait_for_drain();
    end
    repeat (24) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### hilbert_fir_transformer.f
src/hft_pkg.sv
src/hft_cell.sv
src/hft_tree.sv
src/hilbert_fir_transformer.sv
verif/hilbert_fir_transformer_tb.sv
